[rtl/cptl_pkg.sv]
// Shared widths, types and step functions for the circle pair tangent line block.
// Used by every module of the block and by its port checker; depends on nothing.
`default_nettype none

package cptl_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int DW          = COORD_WIDTH + 1;
  localparam int SW          = 2 * COORD_WIDTH + 1;
  localparam int EXTRA_BITS  = (123 - 2 * COORD_WIDTH) / 2;
  localparam int SQW         = (SW + 2 * EXTRA_BITS + 1) / 2;
  localparam int SQRW        = SQW + 2;
  localparam int RADW        = 2 * SQW;
  localparam int LOW_W       = SQW / 2;
  localparam int HIGH_W      = SQW - LOW_W;
  localparam int TW          = SQW + COORD_WIDTH;
  localparam int QMW         = TW + 1;
  localparam int QW          = QMW + 1;
  localparam int DRW         = QMW + 1;
  localparam int UNIT_BITS   = 32;
  localparam int NQW         = UNIT_BITS + 1;
  localparam int PW          = RAD_WIDTH + NQW;
  localparam int OFFW        = PW + 1 - UNIT_BITS;
  localparam int SUMW        = OFFW + 2;

  localparam int IN_BITS = 4 * COORD_WIDTH + 2 * RAD_WIDTH;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W   = 4 * COORD_WIDTH;
  localparam int USER_W  = 3;

  localparam int USER_KIND_BIT   = 0;
  localparam int USER_INDEX_BIT  = 1;
  localparam int USER_EXISTS_BIT = 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic [RAD_WIDTH-1:0]          ra;
    logic [RAD_WIDTH-1:0]          rb;
    logic                          kind;
    logic                          idx;
    logic                          last;
    logic                          ex;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } job_t;

  typedef struct packed {
    tag_t                   tag;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [2*DW-1:0] kdx;
    logic signed [2*DW-1:0] kdy;
    logic [SW-1:0]          s;
  } sq_side_t;

  typedef struct packed {
    tag_t tag;
    logic qxneg;
    logic qyneg;
  } dv_side_t;

  typedef struct packed {
    logic [SQRW-1:0] rem;
    logic [SQW-1:0]  root;
    logic [RADW-1:0] x;
  } sq_st_t;

  typedef struct packed {
    logic [DRW-1:0] remx;
    logic [DRW-1:0] remy;
    logic [QMW-1:0] den;
    logic [NQW-1:0] qx;
    logic [NQW-1:0] qy;
  } dv_st_t;

  // One result bit of the digit-by-digit square root.
  function automatic sq_st_t sqrt_step(sq_st_t a);
    sq_st_t          r;
    logic [SQRW-1:0] r2;
    logic [SQRW-1:0] trial;
    logic            ge;
    r2     = {a.rem[SQRW-3:0], a.x[RADW-1 -: 2]};
    trial  = {1'b0, a.root[SQW-2:0], 2'b01};
    ge     = (r2 >= trial);
    r.rem  = ge ? (r2 - trial) : r2;
    r.root = {a.root[SQW-2:0], ge};
    r.x    = {a.x[RADW-3:0], 2'b00};
    return r;
  endfunction

  // One quotient bit of both restoring divisions against the shared divisor.
  function automatic dv_st_t div_step(dv_st_t a);
    dv_st_t         r;
    logic [DRW-1:0] d;
    logic [DRW-1:0] sx;
    logic [DRW-1:0] sy;
    logic           gx;
    logic           gy;
    d      = DRW'(a.den);
    gx     = (a.remx >= d);
    gy     = (a.remy >= d);
    sx     = gx ? (a.remx - d) : a.remx;
    sy     = gy ? (a.remy - d) : a.remy;
    r.remx = {sx[DRW-2:0], 1'b0};
    r.remy = {sy[DRW-2:0], 1'b0};
    r.den  = a.den;
    r.qx   = {a.qx[NQW-2:0], gx};
    r.qy   = {a.qy[NQW-2:0], gy};
    return r;
  endfunction

  // Rounds radius times unit component to an integer, ties away from zero.
  function automatic logic signed [OFFW:0] round_off(logic [PW-1:0] p, logic neg);
    logic [PW:0]        t;
    logic [OFFW-1:0]    m;
    logic signed [OFFW:0] r;
    t = {1'b0, p} + ({{PW{1'b0}}, 1'b1} << (UNIT_BITS - 1));
    m = t[PW:UNIT_BITS];
    r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    logic [COORD_WIDTH-1:0] r;
    hi = {{(SUMW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    lo = {{(SUMW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
    if (v > hi) begin
      r = hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      r = lo[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/cptl_issue.sv]
// Input stage: holds one pair of circles and issues its four tangent jobs in turn.
// Depends on cptl_pkg.
`default_nettype none

module cptl_issue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cptl_pkg::IN_W-1:0] in_data,
  input  logic                     ce,
  output cptl_pkg::job_t           job
);
  import cptl_pkg::*;

  localparam int RW = RAD_WIDTH;
  localparam int CW = COORD_WIDTH;

  logic       busy;
  logic [1:0] sel;
  tag_t       item;
  logic       take;

  assign in_ready = !busy || ((&sel) && ce);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      sel  <= '0;
    end else if (busy && ce) begin
      sel <= sel + 2'd1;
      if (&sel) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.ax   <= in_data[CW-1:0];
      item.ay   <= in_data[2*CW-1:CW];
      item.ra   <= in_data[2*CW+RW-1:2*CW];
      item.bx   <= in_data[3*CW+RW-1:2*CW+RW];
      item.by   <= in_data[4*CW+RW-1:3*CW+RW];
      item.rb   <= in_data[4*CW+2*RW-1:4*CW+RW];
      item.kind <= 1'b0;
      item.idx  <= 1'b0;
      item.last <= 1'b0;
      item.ex   <= 1'b0;
    end
  end

  always_comb begin
    job.valid    = busy;
    job.tag      = item;
    job.tag.kind = sel[1];
    job.tag.idx  = sel[0];
    job.tag.last = &sel;
    job.tag.ex   = 1'b0;
  end

endmodule

`default_nettype wire

[rtl/cptl_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on cptl_pkg; carries the job side data alongside the root.
`default_nettype none

module cptl_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [cptl_pkg::RADW-1:0] in_rad,
  input  cptl_pkg::sq_side_t        in_side,
  output logic                      out_valid,
  output logic [cptl_pkg::SQW-1:0]  out_root,
  output cptl_pkg::sq_side_t        out_side
);
  import cptl_pkg::*;

  sq_st_t         st_in;
  sq_st_t         st      [0:SQW-1];
  sq_st_t         st_next [0:SQW-1];
  sq_side_t       side    [0:SQW-1];
  logic [SQW-1:0] vld;

  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.x    = in_rad;
    st_next[0] = sqrt_step(st_in);
    for (int i = 1; i < SQW; i++) begin
      st_next[i] = sqrt_step(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[SQW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= in_side;
      for (int i = 0; i < SQW; i++) begin
        st[i] <= st_next[i];
      end
      for (int i = 1; i < SQW; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[SQW-1];
  assign out_root  = st[SQW-1].root;
  assign out_side  = side[SQW-1];

endmodule

`default_nettype wire

[rtl/cptl_div.sv]
// Pipelined fractional divider, two numerators over one divisor, one quotient
// bit per register stage. Depends on cptl_pkg.
`default_nettype none

module cptl_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     in_valid,
  input  logic [cptl_pkg::QMW-1:0] num_x,
  input  logic [cptl_pkg::QMW-1:0] num_y,
  input  logic [cptl_pkg::QMW-1:0] den,
  input  cptl_pkg::dv_side_t       in_side,
  output logic                     out_valid,
  output logic [cptl_pkg::NQW-1:0] quot_x,
  output logic [cptl_pkg::NQW-1:0] quot_y,
  output cptl_pkg::dv_side_t       out_side
);
  import cptl_pkg::*;

  dv_st_t         st_in;
  dv_st_t         st      [0:NQW-1];
  dv_st_t         st_next [0:NQW-1];
  dv_side_t       side    [0:NQW-1];
  logic [NQW-1:0] vld;

  always_comb begin
    st_in.remx = DRW'(num_x);
    st_in.remy = DRW'(num_y);
    st_in.den  = den;
    st_in.qx   = '0;
    st_in.qy   = '0;
    st_next[0] = div_step(st_in);
    for (int i = 1; i < NQW; i++) begin
      st_next[i] = div_step(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NQW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= in_side;
      for (int i = 0; i < NQW; i++) begin
        st[i] <= st_next[i];
      end
      for (int i = 1; i < NQW; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[NQW-1];
  assign quot_x    = st[NQW-1].qx;
  assign quot_y    = st[NQW-1].qy;
  assign out_side  = side[NQW-1];

endmodule

`default_nettype wire

[rtl/circle_pair_tangent_lines_top.sv]
// Top level of the circle pair common tangent block: issue stage, geometry
// pipeline, square root and divider. Depends on cptl_pkg, cptl_issue,
// cptl_sqrt and cptl_div.
//
//   channel  direction  signals                      carries
//   s_*      in         tvalid tready tdata          two circles (centers, radii)
//   m_*      out        tvalid tready tdata tuser    one tangent segment per transfer
//                       tlast
//
// Each input request yields four results, one per cycle while the output does not stall;
// the issue stage takes a new request only as it issues the last job of the current one.
// From acceptance to the first result, a job passes the geometry registers, the
// 62-stage square root and the 33-stage divider.
// rst is synchronous and clears only the valid bits and the issue stage.
// When m_tready is low while m_tvalid is high the whole pipeline holds; nothing is dropped or repeated.
`default_nettype none

module circle_pair_tangent_lines_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // ax, ay, ra, bx, by, rb, zero pad
  input  logic [cptl_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // touch_a_x, touch_a_y, touch_b_x, touch_b_y
  output logic [cptl_pkg::OUT_W-1:0]  m_tdata,
  // tangent_kind, tangent_index, exists
  output logic [cptl_pkg::USER_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import cptl_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic ce;
  job_t job;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;

  tag_t                   tag1, tag2, tag3;
  tag_t                   tag3x;
  logic signed [DW-1:0]   dx1, dy1, k1, dx2, dy2, dx3, dy3;
  logic signed [2*DW-1:0] dxx2, dyy2, kk2, kdx2, kdy2, kdx3, kdy3;
  logic [SW-1:0]          s3;
  logic [2*CW-1:0]        kk3;

  logic                   ex_c;
  logic [SW-1:0]          diff_c;
  logic [RADW-1:0]        rad4;
  sq_side_t               side4;
  logic                   v4_ex;

  logic                   sq_v;
  logic [SQW-1:0]         root;
  sq_side_t               sside;

  logic [CW-1:0]          dxm_c, dym_c;
  logic [LOW_W+CW-1:0]    pdx_lo5, pdy_lo5;
  logic [HIGH_W+CW-1:0]   pdx_hi5, pdy_hi5;
  sq_side_t               side5, side6, side7;
  logic [TW-1:0]          tdxm6, tdym6;

  logic signed [QW-1:0]   tdx_c, tdy_c, kdxe_c, kdye_c;
  logic signed [QW-1:0]   qx7, qy7;

  logic [QMW-1:0]         numx8, numy8, den8;
  dv_side_t               dside8;

  logic                   dv_v;
  logic [NQW-1:0]         nqx, nqy;
  dv_side_t               dside;

  logic [PW-1:0]          pax9, pay9, pbx9, pby9;
  dv_side_t               dside9;

  logic signed [OFFW:0]   oax_c, oay_c, obx_c, oby_c;
  logic signed [SUMW-1:0] sax10, say10, sbx10, sby10;
  tag_t                   tag10;

  assign ce = !m_tvalid || m_tready;

  cptl_issue u_issue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .ce       (ce),
    .job      (job)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      v6       <= 1'b0;
      v7       <= 1'b0;
      v8       <= 1'b0;
      v9       <= 1'b0;
      v10      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      v1       <= job.valid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= sq_v;
      v6       <= v5;
      v7       <= v6;
      v8       <= v7;
      v9       <= dv_v;
      v10      <= v9;
      m_tvalid <= v10;
    end
  end

  always_comb begin
    diff_c   = s3 - SW'(kk3);
    ex_c     = (s3 != '0) && (SW'(kk3) <= s3);
    tag3x    = tag3;
    tag3x.ex = ex_c;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tag1 <= job.tag;
      dx1  <= DW'(job.tag.bx) - DW'(job.tag.ax);
      dy1  <= DW'(job.tag.by) - DW'(job.tag.ay);
      k1   <= job.tag.kind ? (DW'(job.tag.ra) + DW'(job.tag.rb))
                           : (DW'(job.tag.ra) - DW'(job.tag.rb));

      tag2 <= tag1;
      dx2  <= dx1;
      dy2  <= dy1;
      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      kk2  <= k1 * k1;
      kdx2 <= k1 * dx1;
      kdy2 <= k1 * dy1;

      tag3 <= tag2;
      dx3  <= dx2;
      dy3  <= dy2;
      kdx3 <= kdx2;
      kdy3 <= kdy2;
      s3   <= SW'(dxx2[2*CW-1:0]) + SW'(dyy2[2*CW-1:0]);
      kk3  <= kk2[2*CW-1:0];

      side4.tag    <= tag3x;
      side4.dx     <= dx3;
      side4.dy     <= dy3;
      side4.kdx    <= kdx3;
      side4.kdy    <= kdy3;
      side4.s      <= s3;
      rad4         <= ex_c ? (RADW'(diff_c) << (2 * EXTRA_BITS)) : '0;
    end
  end

  assign v4_ex = v4;

  cptl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v4_ex),
    .in_rad    (rad4),
    .in_side   (side4),
    .out_valid (sq_v),
    .out_root  (root),
    .out_side  (sside)
  );

  always_comb begin
    dxm_c  = sside.dx[DW-1] ? CW'(-sside.dx) : CW'(sside.dx);
    dym_c  = sside.dy[DW-1] ? CW'(-sside.dy) : CW'(sside.dy);
    tdx_c  = side6.dx[DW-1] ? -$signed(QW'(tdxm6)) : $signed(QW'(tdxm6));
    tdy_c  = side6.dy[DW-1] ? -$signed(QW'(tdym6)) : $signed(QW'(tdym6));
    kdxe_c = QW'(side6.kdx) <<< EXTRA_BITS;
    kdye_c = QW'(side6.kdy) <<< EXTRA_BITS;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side5   <= sside;
      pdx_lo5 <= root[LOW_W-1:0] * dxm_c;
      pdx_hi5 <= root[SQW-1:LOW_W] * dxm_c;
      pdy_lo5 <= root[LOW_W-1:0] * dym_c;
      pdy_hi5 <= root[SQW-1:LOW_W] * dym_c;

      side6 <= side5;
      tdxm6 <= (TW'(pdx_hi5) << LOW_W) + TW'(pdx_lo5);
      tdym6 <= (TW'(pdy_hi5) << LOW_W) + TW'(pdy_lo5);

      side7 <= side6;

      qx7 <= side6.tag.idx ? (kdxe_c + tdy_c) : (kdxe_c - tdy_c);
      qy7 <= side6.tag.idx ? (kdye_c - tdx_c) : (kdye_c + tdx_c);
      dside8.tag <= side7.tag;

      numx8        <= qx7[QW-1] ? QMW'(-qx7) : QMW'(qx7);
      numy8        <= qy7[QW-1] ? QMW'(-qy7) : QMW'(qy7);
      den8         <= QMW'(side7.s) << EXTRA_BITS;
      dside8.qxneg <= qx7[QW-1];
      dside8.qyneg <= qy7[QW-1];
    end
  end

  cptl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v8),
    .num_x     (numx8),
    .num_y     (numy8),
    .den       (den8),
    .in_side   (dside8),
    .out_valid (dv_v),
    .quot_x    (nqx),
    .quot_y    (nqy),
    .out_side  (dside)
  );

  always_comb begin
    oax_c = round_off(pax9, dside9.qxneg);
    oay_c = round_off(pay9, dside9.qyneg);
    obx_c = round_off(pbx9, dside9.qxneg ^ dside9.tag.kind);
    oby_c = round_off(pby9, dside9.qyneg ^ dside9.tag.kind);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dside9 <= dside;
      pax9   <= dside.tag.ra * nqx;
      pay9   <= dside.tag.ra * nqy;
      pbx9   <= dside.tag.rb * nqx;
      pby9   <= dside.tag.rb * nqy;

      tag10 <= dside9.tag;
      sax10 <= SUMW'(dside9.tag.ax) + SUMW'(oax_c);
      say10 <= SUMW'(dside9.tag.ay) + SUMW'(oay_c);
      sbx10 <= SUMW'(dside9.tag.bx) + SUMW'(obx_c);
      sby10 <= SUMW'(dside9.tag.by) + SUMW'(oby_c);

      if (tag10.ex) begin
        m_tdata <= {sat_coord(sby10), sat_coord(sbx10), sat_coord(say10), sat_coord(sax10)};
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= {tag10.ex, tag10.idx, tag10.kind};
      m_tlast <= tag10.last;
    end
  end

endmodule

`default_nettype wire

[rtl/cptl_checker.sv]
// Port checker for the circle pair tangent line block, bound to its top level.
// Depends on cptl_pkg and circle_pair_tangent_lines_top.
`default_nettype none

module cptl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [cptl_pkg::OUT_W-1:0]  m_tdata,
  input logic [cptl_pkg::USER_W-1:0] m_tuser,
  input logic                        m_tlast
);
  import cptl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_EXISTS_BIT] |-> m_tdata == '0)
    else $error("absent tangent carries nonzero touch points");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (m_tuser[USER_KIND_BIT] && m_tuser[USER_INDEX_BIT]))
    else $error("tlast not on the second internal tangent");

  a_one_per_four: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is still being issued");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind circle_pair_tangent_lines_top cptl_checker u_cptl_checker (.*);

`default_nettype wire

[verif/circle_pair_tangent_lines_top_tb.sv]
// Self-checking testbench for circle_pair_tangent_lines_top: drives circle pairs over the
// input stream and checks every tangent segment against a predictor of its own.
// Depends on cptl_pkg and the block's RTL.
`timescale 1ns / 1ps

module circle_pair_tangent_lines_top_tb;
  import cptl_pkg::*;

  localparam int EXTRA = 29;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
    logic [30:0]        ra, rb;
  } circles_t;

  typedef struct packed {
    logic               kind, idx, ex, last;
    logic signed [31:0] tax, tay, tbx, tby;
  } segment_t;

  typedef struct {
    circles_t c;
    bit       known;
  } row_t;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 s_tvalid = 0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 0;
  logic [OUT_W-1:0]     m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 m_tlast;

  segment_t expected_segs[$];
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int requests = 0;
  int segments = 0;
  int found_ext = 0;
  int found_int = 0;
  bit done = 0;

  circle_pair_tangent_lines_top u_top (.*);

  always #5 clk = ~clk;

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [63:0] isqrt(logic [255:0] x);
    logic [63:0] res;
    logic [63:0] c;
    res = 0;
    for (int b = 62; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({192'd0, c} * {192'd0, c} <= x) res = c;
    end
    return res;
  endfunction

  function automatic longint offset(logic [30:0] r, logic signed [255:0] q, logic [255:0] den);
    logic [255:0] m;
    logic [255:0] nq;
    logic [255:0] p;
    longint       v;
    m  = q[255] ? -q : q;
    nq = (m << 32) / den;
    p  = ({225'd0, r} * nq + (256'd1 << 31)) >> 32;
    v  = longint'(p[62:0]);
    return q[255] ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void predict_tangents(circles_t c);
    longint             dx, dy, k;
    logic signed [255:0] sdx, sdy, sk, s, kk, qx, qy, l2;
    logic               ex;
    segment_t           g;
    dx  = longint'(c.bx) - longint'(c.ax);
    dy  = longint'(c.by) - longint'(c.ay);
    sdx = dx;
    sdy = dy;
    s   = sdx * sdx + sdy * sdy;
    for (int kind = 0; kind < 2; kind++) begin
      k  = kind ? longint'(c.ra) + longint'(c.rb) : longint'(c.ra) - longint'(c.rb);
      sk = k;
      kk = sk * sk;
      ex = (s != 0) && (s >= kk);
      l2 = ex ? {192'd0, isqrt((s - kk) << (2 * EXTRA))} : '0;
      if (ex) begin
        if (kind) found_int++;
        else found_ext++;
      end
      for (int idx = 0; idx < 2; idx++) begin
        g.kind = kind;
        g.idx  = idx;
        g.ex   = ex;
        g.last = (kind == 1 && idx == 1);
        g.tax  = 0;
        g.tay  = 0;
        g.tbx  = 0;
        g.tby  = 0;
        if (ex) begin
          qx = ((sk * sdx) <<< EXTRA) + (idx ? l2 * sdy : -(l2 * sdy));
          qy = ((sk * sdy) <<< EXTRA) + (idx ? -(l2 * sdx) : l2 * sdx);
          g.tax = clamp(longint'(c.ax) + offset(c.ra, qx, s << EXTRA));
          g.tay = clamp(longint'(c.ay) + offset(c.ra, qy, s << EXTRA));
          if (kind) begin
            g.tbx = clamp(longint'(c.bx) - offset(c.rb, qx, s << EXTRA));
            g.tby = clamp(longint'(c.by) - offset(c.rb, qy, s << EXTRA));
          end else begin
            g.tbx = clamp(longint'(c.bx) + offset(c.rb, qx, s << EXTRA));
            g.tby = clamp(longint'(c.by) + offset(c.rb, qy, s << EXTRA));
          end
        end
        expected_segs.push_back(g);
      end
    end
  endfunction

  // With no tangents at all, every segment is flags only and zero touch points.
  function automatic void expect_no_tangents();
    segment_t g;
    for (int n = 0; n < 4; n++) begin
      g.kind = n[1];
      g.idx  = n[0];
      g.ex   = 0;
      g.last = (n == 3);
      g.tax  = 0;
      g.tay  = 0;
      g.tbx  = 0;
      g.tby  = 0;
      expected_segs.push_back(g);
    end
  endfunction

  task automatic send_request(circles_t c, bit known);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {2'b00, c.rb, c.by, c.bx, c.ra, c.ay, c.ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (known) expect_no_tangents();
    else predict_tangents(c);
    requests++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    segment_t e;
    segment_t a;
    if (!rst && m_tvalid && m_tready) begin
      segments++;
      a.tax  = m_tdata[31:0];
      a.tay  = m_tdata[63:32];
      a.tbx  = m_tdata[95:64];
      a.tby  = m_tdata[127:96];
      a.kind = m_tuser[USER_KIND_BIT];
      a.idx  = m_tuser[USER_INDEX_BIT];
      a.ex   = m_tuser[USER_EXISTS_BIT];
      a.last = m_tlast;
      if (expected_segs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected segment: tuser=%b tdata=%h", m_tuser, m_tdata);
      end else begin
        e = expected_segs.pop_front();
        if (e != a) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected kind=%0d idx=%0d ex=%0d last=%0d a=(%0d,%0d) b=(%0d,%0d)",
                     e.kind, e.idx, e.ex, e.last, e.tax, e.tay, e.tbx, e.tby,
                     "\n          actual   kind=%0d idx=%0d ex=%0d last=%0d a=(%0d,%0d) b=(%0d,%0d)",
                     a.kind, a.idx, a.ex, a.last, a.tax, a.tay, a.tbx, a.tby);
        end
      end
    end
  end

  function automatic circles_t random_pair();
    circles_t c;
    int       mode;
    int       d;
    mode = $urandom_range(99);
    c.ax = $urandom;
    c.ay = $urandom;
    c.bx = $urandom;
    c.by = $urandom;
    c.ra = $urandom;
    c.rb = $urandom;
    if (mode < 50) begin
      c.ax = $signed($urandom_range(1 << 22)) - (1 << 21);
      c.ay = $signed($urandom_range(1 << 22)) - (1 << 21);
      c.bx = $signed($urandom_range(1 << 22)) - (1 << 21);
      c.by = $signed($urandom_range(1 << 22)) - (1 << 21);
      c.ra = $urandom_range(1 << 20);
      c.rb = $urandom_range(1 << 20);
    end else if (mode < 60) begin
      c.bx = c.ax;
      c.by = c.ay;
    end else if (mode < 80) begin
      d    = $urandom_range(1 << 24, 1);
      c.ax = $signed($urandom_range(1 << 24)) - (1 << 23);
      c.ay = $signed($urandom_range(1 << 24)) - (1 << 23);
      c.ra = $urandom_range(d);
      if ($urandom_range(1)) begin
        c.bx = c.ax + d;
        c.by = c.ay;
      end else begin
        c.bx = c.ax;
        c.by = c.ay - d;
      end
      c.rb = $urandom_range(1) ? d - c.ra : d + c.ra;
    end else if (mode < 90) begin
      c.ax = $signed($urandom_range(1 << 20)) - (1 << 19);
      c.ay = $signed($urandom_range(1 << 20)) - (1 << 19);
      c.bx = c.ax + $signed($urandom_range(64)) - 32;
      c.by = c.ay + $signed($urandom_range(64)) - 32;
      c.ra = $urandom_range(1 << 20, 1 << 10);
      c.rb = $urandom_range(1 << 8);
    end
    return c;
  endfunction

  row_t rows[] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd65536, 31'd65536}, 1},
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0}, 1},
    '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd0, 31'd0}, 0},
    '{'{32'sd0, 32'sd0, 32'sd131072, 32'sd0, 31'd65536, 31'd65536}, 0},
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 31'd131072, 31'd65536}, 0},
    '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 31'd655360, 31'd131072}, 1},
    '{'{32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 31'd65536, 31'd65536}, 0},
    '{'{32'sd100, -32'sd200, 32'sd300000, 32'sd400000, 31'd1000, 31'd5000}, 0},
    '{'{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff}, 0},
    '{'{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'd0}, 0},
    '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff}, 1},
    '{'{32'sh80000000, 32'sd0, 32'sh7fffffff, 32'sd0, 31'd0, 31'h7fffffff}, 0},
    '{'{-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 31'd1, 31'h7fffffff}, 1},
    '{'{32'sd0, 32'sd0, 32'sd1, 32'sd0, 31'd0, 31'd1}, 0},
    '{'{32'sh7fff0000, 32'sd0, 32'sh80010000, 32'sd0, 31'd65536, 31'd65536}, 0}
  };

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (rows[n]) send_request(rows[n].c, rows[n].known);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      for (int n = 0; n < 116; n++) send_request(random_pair(), 0);
    end
    s_tvalid <= 0;
    recv_stall = 0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d circle pairs, checked %0d segments (%0d external and %0d internal kinds present).",
             requests, segments, found_ext, found_int);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d segments outstanding", expected_segs.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
